FILE: rtl/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int ADDR_W     = 16;
  localparam int IDENT_W    = 16;
  localparam int PADDR_W    = 3;

  localparam logic [ADDR_W-1:0] MEM_SIZE_RST = ADDR_W'(128);

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_FIT    = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // register index (byte address / 4)
  localparam logic REG_MEM_SIZE = 1'b0;

endpackage

FILE: rtl/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// First-fit region allocator. One request is taken at a time: in_stall is high from the
// cycle after a request is accepted until its result has been loaded into the output
// register. An allocate scans one table entry per cycle for the first gap that holds the
// requested size (gaps in address order, then the tail gap up to mem_size), then finds
// the insert slot, shifts the table open and loads the result into the output register.
// A full table skips the scan and goes straight to loading its result. in_stall drops on
// the edge that raises out_valid, so the next request can be accepted while that result
// is shown. A free scans ids one per cycle, then removes the match from the table. A
// waiting result that is not taken holds the block in its last step. mem_size is at byte
// address 0 of the register port and resets to 128.
module first_fit_region_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [ffra_pkg::ADDR_W-1:0]   in_alloc_size,
  input  logic [ffra_pkg::IDENT_W-1:0]  in_task_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output ffra_pkg::status_t             out_status,
  output logic [ffra_pkg::ADDR_W-1:0]   out_block_start,
  output logic [ffra_pkg::ADDR_W-1:0]   out_block_end,
  output logic [ffra_pkg::IDENT_W-1:0]  out_block_id,
  // register port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ffra_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import ffra_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_POS    = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_FSCAN  = 3'd4;
  localparam logic [2:0] S_REMOVE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_r;
  logic [ADDR_W-1:0]   mem_size_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDENT_W-1:0]  next_ident_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    pos_r;
  logic [ADDR_W-1:0]   prev_end_r;
  logic [ADDR_W-1:0]   size_r;
  logic [IDENT_W-1:0]  ident_r;

  status_t             res_status_r;
  logic [ADDR_W-1:0]   res_start_r;
  logic [ADDR_W-1:0]   res_end_r;
  logic [IDENT_W-1:0]  res_id_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [ADDR_W-1:0]   out_start_r;
  logic [ADDR_W-1:0]   out_end_r;
  logic [IDENT_W-1:0]  out_id_r;

  logic [ADDR_W-1:0]   entry_start [MAX_BLOCKS];
  logic [ADDR_W-1:0]   entry_end   [MAX_BLOCKS];
  logic [IDENT_W-1:0]  entry_ident [MAX_BLOCKS];

  logic                accept;
  logic                scan_end;
  logic [IDX_W-1:0]    scan_idx;
  logic [ADDR_W-1:0]   cur_start;
  logic [ADDR_W-1:0]   cur_end;
  logic [IDENT_W-1:0]  cur_ident;
  logic                gap_fits;
  logic                tail_fits;
  logic [IDX_W-1:0]    pos_nxt;
  logic                out_free;
  logic [ADDR_W-1:0]   new_end;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign scan_end  = (cnt_r == count_r);
  assign scan_idx  = cnt_r[IDX_W-1:0];
  assign cur_start = entry_start[scan_idx];
  assign cur_end   = entry_end[scan_idx];
  assign cur_ident = entry_ident[scan_idx];
  assign gap_fits  = (cur_start >= prev_end_r) && ((cur_start - prev_end_r) >= size_r);
  assign tail_fits = (prev_end_r <= mem_size_r) && ((mem_size_r - prev_end_r) >= size_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign new_end   = prev_end_r + size_r;

  // insert after every entry whose start is not above the new start
  always_comb begin
    pos_nxt = count_r[IDX_W-1:0];
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_r) && (entry_start[i] > prev_end_r)) begin
        pos_nxt = IDX_W'(i);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      next_ident_r <= '0;
      mem_size_r   <= MEM_SIZE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MEM_SIZE)) begin
        mem_size_r <= cfg_pwdata[ADDR_W-1:0];
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_ALLOC) begin
              next_ident_r <= next_ident_r + 1'b1;
              state_r      <= (count_r == CNT_W'(MAX_BLOCKS)) ? S_DONE : S_SCAN;
            end else begin
              state_r <= S_FSCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state_r <= tail_fits ? S_POS : S_DONE;
          end else if (gap_fits) begin
            state_r <= S_POS;
          end
        end
        S_POS: state_r <= S_INSERT;
        S_INSERT: begin
          count_r <= count_r + 1'b1;
          state_r <= S_DONE;
        end
        S_FSCAN: begin
          if (scan_end) begin
            state_r <= S_DONE;
          end else if (cur_ident == ident_r) begin
            state_r <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          count_r <= count_r - 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cnt_r      <= '0;
        prev_end_r <= '0;
        size_r     <= in_alloc_size;
        ident_r    <= (in_req_type == REQ_ALLOC) ? next_ident_r : in_task_id;
        res_status_r <= ST_FULL;
        res_start_r  <= '0;
        res_end_r    <= '0;
        res_id_r     <= next_ident_r;
      end
      S_SCAN: begin
        if (scan_end) begin
          if (!tail_fits) begin
            res_status_r <= ST_NO_FIT;
            res_id_r     <= ident_r;
          end
        end else if (!gap_fits) begin
          prev_end_r <= cur_end;
          cnt_r      <= cnt_r + 1'b1;
        end
      end
      S_POS: pos_r <= pos_nxt;
      S_INSERT: begin
        res_status_r <= ST_OK;
        res_start_r  <= prev_end_r;
        res_end_r    <= new_end;
        res_id_r     <= ident_r;
      end
      S_FSCAN: begin
        if (scan_end) begin
          res_status_r <= ST_NOT_FOUND;
          res_start_r  <= '0;
          res_end_r    <= '0;
          res_id_r     <= '0;
        end else if (cur_ident == ident_r) begin
          pos_r        <= scan_idx;
          res_status_r <= ST_OK;
          res_start_r  <= cur_start;
          res_end_r    <= cur_end;
          res_id_r     <= ident_r;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_end_r    <= res_end_r;
      out_id_r     <= res_id_r;
    end
  end

  // table storage: shift open on insert, shift closed on remove
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (state_r == S_INSERT) begin
        if (IDX_W'(i) == pos_r) begin
          entry_start[i] <= prev_end_r;
          entry_end[i]   <= new_end;
          entry_ident[i] <= ident_r;
        end else if ((i > 0) && (IDX_W'(i) > pos_r) && (CNT_W'(i) <= count_r)) begin
          entry_start[i] <= entry_start[(i > 0) ? i - 1 : 0];
          entry_end[i]   <= entry_end[(i > 0) ? i - 1 : 0];
          entry_ident[i] <= entry_ident[(i > 0) ? i - 1 : 0];
        end
      end else if (state_r == S_REMOVE) begin
        if ((i < MAX_BLOCKS - 1) && (IDX_W'(i) >= pos_r)) begin
          entry_start[i] <= entry_start[(i < MAX_BLOCKS - 1) ? i + 1 : i];
          entry_end[i]   <= entry_end[(i < MAX_BLOCKS - 1) ? i + 1 : i];
          entry_ident[i] <= entry_ident[(i < MAX_BLOCKS - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_start_r;
  assign out_block_end   = out_end_r;
  assign out_block_id    = out_id_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MEM_SIZE) ? {{(32 - ADDR_W){1'b0}}, mem_size_r}
                                                     : 32'd0;

endmodule
